/* sv/per_class_box_nms_defines.svh */
// Assertion helpers shared by the RTL of the box suppression block.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef PER_CLASS_BOX_NMS_DEFINES_SVH
`define PER_CLASS_BOX_NMS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCBN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCBN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pcbn_pkg.sv */
// ----------------------------------------------------------------------------
// pcbn_pkg
// Shared constants, payload types and state encoding of the per-class box
// suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbn_pkg;

    localparam int MAX_DET     = 64;
    localparam int ADDR_W      = $clog2(MAX_DET);
    localparam int CNT_W       = $clog2(MAX_DET + 1);
    localparam int NUM_CLASSES = 16;
    localparam int COORD_BITS  = 16;
    localparam int THR_W       = 17;
    localparam int IDX_W       = 6;

    localparam logic [THR_W-1:0] THR_RESET = 17'd19661;

    // Command codes of an input transaction.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_min;
        logic [COORD_BITS-1:0] y_min;
        logic [COORD_BITS-1:0] x_max;
        logic [COORD_BITS-1:0] y_max;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    typedef struct packed {
        logic                   cmd;
        logic [COORD_BITS-1:0]  x_min;
        logic [COORD_BITS-1:0]  y_min;
        logic [COORD_BITS-1:0]  x_max;
        logic [COORD_BITS-1:0]  y_max;
        logic [NUM_CLASSES-1:0] class_bits;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]       det_index;
        logic [NUM_CLASSES-1:0] kept_classes;
        logic                   last;
    } out_item_t;

    // Result of the overlap unit, one cycle wide.
    typedef struct packed {
        logic done;
        logic hit;
    } iou_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_COL_RD,
        ST_COL_WAIT,
        ST_COL_CALC,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } state_t;

endpackage

`default_nettype wire

/* sv/pcbn_ram.sv */
// ----------------------------------------------------------------------------
// pcbn_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered and held while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/pcbn_iou.sv */
// ----------------------------------------------------------------------------
// pcbn_iou
// Five-stage overlap test of two boxes: reports a hit when
// intersection * 65536 >= threshold * union, and never for an empty
// intersection or a box of zero area.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbn_iou (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire pcbn_pkg::box_t              box_a,
    input  wire pcbn_pkg::box_t              box_b,
    input  wire logic [pcbn_pkg::THR_W-1:0]  thr,
    output pcbn_pkg::iou_res_t               res
);

    localparam int CW = pcbn_pkg::COORD_BITS;
    localparam int AW = 2 * CW;

    logic [4:0] vld_reg;

    logic [CW-1:0] wa_reg, ha_reg, wb_reg, hb_reg, iw_reg, ih_reg;
    logic [AW-1:0] area_a_reg, area_b_reg, inter2_reg;
    logic [AW+1:0] uni_reg;
    logic [AW-1:0] inter3_reg;
    logic          zero3_reg;
    logic [AW+pcbn_pkg::THR_W:0] prod_reg;
    logic [AW+15:0] lhs_reg;
    logic           zero4_reg;
    logic           hit_reg;

    logic [CW-1:0] ix0, iy0, ix1, iy1;
    logic [AW+1:0] uni_next;

    // Clipped corners of the intersection.
    always_comb
    begin
        ix0 = (box_a.x_min > box_b.x_min) ? box_a.x_min : box_b.x_min;
        iy0 = (box_a.y_min > box_b.y_min) ? box_a.y_min : box_b.y_min;
        ix1 = (box_a.x_max < box_b.x_max) ? box_a.x_max : box_b.x_max;
        iy1 = (box_a.y_max < box_b.y_max) ? box_a.y_max : box_b.y_max;
        uni_next = {2'b00, area_a_reg} + {2'b00, area_b_reg} - {2'b00, inter2_reg};
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

    // Datapath: spans, areas, union, product, compare.
    always_ff @(posedge clk)
    begin
        wa_reg <= (box_a.x_max > box_a.x_min) ? box_a.x_max - box_a.x_min : '0;
        ha_reg <= (box_a.y_max > box_a.y_min) ? box_a.y_max - box_a.y_min : '0;
        wb_reg <= (box_b.x_max > box_b.x_min) ? box_b.x_max - box_b.x_min : '0;
        hb_reg <= (box_b.y_max > box_b.y_min) ? box_b.y_max - box_b.y_min : '0;
        iw_reg <= (ix1 > ix0) ? ix1 - ix0 : '0;
        ih_reg <= (iy1 > iy0) ? iy1 - iy0 : '0;

        area_a_reg <= wa_reg * ha_reg;
        area_b_reg <= wb_reg * hb_reg;
        inter2_reg <= iw_reg * ih_reg;

        uni_reg    <= uni_next;
        inter3_reg <= inter2_reg;
        zero3_reg  <= (inter2_reg == '0) || (area_a_reg == '0) || (area_b_reg == '0);

        prod_reg  <= uni_reg[AW:0] * thr;
        lhs_reg   <= {inter3_reg, 16'h0000};
        zero4_reg <= zero3_reg;

        hit_reg <= !zero4_reg && ({2'b00, lhs_reg} >= prod_reg);
    end

    assign res.done = vld_reg[4];
    assign res.hit  = hit_reg;

endmodule

`default_nettype wire

/* sv/per_class_box_nms.sv */
// ----------------------------------------------------------------------------
// per_class_box_nms
// Greedy per-class non-maximum suppression over up to 64 loaded boxes,
// with the boxes and class masks kept in two RAMs.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                       Direction  Transaction
//  in        in_valid, in_stall, in_data   input      load one box or run
//  out       out_valid, out_stall, out_data output    one kept class mask
//  cfg       cfg_valid, cfg_ready, cfg_data input     overlap threshold
//
//  A load is written straight from the idle state. A run spends a column
//  read, its wait and the overlap unit on each box pair, a row read and its
//  wait on each row, and a read and its wait on each emitted result.
//  Reset clears the box count and sets the threshold to 0.3; the RAMs need
//  no clearing. A stalled output holds the run; in_stall stays high until
//  the last result has been placed in the output register.
//
`default_nettype none
`include "per_class_box_nms_defines.svh"

module per_class_box_nms (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire pcbn_pkg::in_item_t         in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output pcbn_pkg::out_item_t             out_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [pcbn_pkg::THR_W-1:0] cfg_data
);

    localparam int AW = pcbn_pkg::ADDR_W;
    localparam int CW = pcbn_pkg::CNT_W;
    localparam int NC = pcbn_pkg::NUM_CLASSES;

    pcbn_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    pcbn_pkg::box_t      box_i_reg, box_i_next;
    logic [NC-1:0]       mask_i_reg, mask_i_next;
    logic [NC-1:0]       mask_j_reg, mask_j_next;
    logic                out_valid_reg, out_valid_next;
    pcbn_pkg::out_item_t out_data_reg, out_data_next;
    logic [pcbn_pkg::THR_W-1:0] thr_reg;

    logic                box_we, mask_we, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    pcbn_pkg::box_t      box_wdata;
    logic [NC-1:0]       mask_wdata;
    logic [pcbn_pkg::BOX_W-1:0] box_rdata;
    logic [NC-1:0]       mask_rdata;
    logic                iou_start;
    pcbn_pkg::iou_res_t  iou_res;
    logic                out_free;
    logic [CW-1:0]       i_inc, j_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != pcbn_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign i_inc     = i_reg + 1'b1;
    assign j_inc     = j_reg + 1'b1;

    // Box and mask storage.
    pcbn_ram #(.WIDTH(pcbn_pkg::BOX_W), .DEPTH(pcbn_pkg::MAX_DET)) u_box_ram (
        .clk   (clk),
        .we    (box_we),
        .waddr (wr_addr),
        .wdata (box_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (box_rdata)
    );

    pcbn_ram #(.WIDTH(NC), .DEPTH(pcbn_pkg::MAX_DET)) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (wr_addr),
        .wdata (mask_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (mask_rdata)
    );

    // Overlap test of the row box against the column box just read.
    pcbn_iou u_iou (
        .clk   (clk),
        .rst_n (rst_n),
        .start (iou_start),
        .box_a (box_i_reg),
        .box_b (pcbn_pkg::box_t'(box_rdata)),
        .thr   (thr_reg),
        .res   (iou_res)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcbn_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= pcbn_pkg::THR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // Payload and loop registers.
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        box_i_reg    <= box_i_next;
        mask_i_reg   <= mask_i_next;
        mask_j_reg   <= mask_j_next;
        out_data_reg <= out_data_next;
    end

    // Sequencer: loads, the pair walk with read-modify-write of masks, and emission.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        box_i_next     = box_i_reg;
        mask_i_next    = mask_i_reg;
        mask_j_next    = mask_j_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        box_we         = 1'b0;
        mask_we        = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        rd_addr        = i_reg[AW-1:0];
        box_wdata.x_min = in_data.x_min;
        box_wdata.y_min = in_data.y_min;
        box_wdata.x_max = in_data.x_max;
        box_wdata.y_max = in_data.y_max;
        mask_wdata     = in_data.class_bits;
        iou_start      = 1'b0;

        case (state_reg)
            pcbn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.cmd == pcbn_pkg::CMD_LOAD)
                    begin
                        if (count_reg < CW'(pcbn_pkg::MAX_DET))
                        begin
                            box_we     = 1'b1;
                            mask_we    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        i_next     = '0;
                        state_next = pcbn_pkg::ST_ROW_RD;
                    end
                end
            end
            pcbn_pkg::ST_ROW_RD:
            begin
                if (i_inc >= count_reg)
                begin
                    j_next     = '0;
                    state_next = pcbn_pkg::ST_EMIT_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg[AW-1:0];
                    state_next = pcbn_pkg::ST_ROW_WAIT;
                end
            end
            pcbn_pkg::ST_ROW_WAIT:
            begin
                box_i_next  = pcbn_pkg::box_t'(box_rdata);
                mask_i_next = mask_rdata;
                j_next      = i_inc;
                state_next  = pcbn_pkg::ST_COL_RD;
            end
            pcbn_pkg::ST_COL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = j_reg[AW-1:0];
                state_next = pcbn_pkg::ST_COL_WAIT;
            end
            pcbn_pkg::ST_COL_WAIT:
            begin
                mask_j_next = mask_rdata;
                iou_start   = 1'b1;
                state_next  = pcbn_pkg::ST_COL_CALC;
            end
            pcbn_pkg::ST_COL_CALC:
            begin
                if (iou_res.done)
                begin
                    wr_addr    = j_reg[AW-1:0];
                    mask_wdata = mask_j_reg & ~mask_i_reg;
                    mask_we    = iou_res.hit && ((mask_i_reg & mask_j_reg) != '0);
                    if (j_inc < count_reg)
                    begin
                        j_next     = j_inc;
                        state_next = pcbn_pkg::ST_COL_RD;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = pcbn_pkg::ST_ROW_RD;
                    end
                end
            end
            pcbn_pkg::ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = j_reg[AW-1:0];
                state_next = pcbn_pkg::ST_EMIT_WAIT;
            end
            pcbn_pkg::ST_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.det_index    = j_reg[pcbn_pkg::IDX_W-1:0];
                    out_data_next.kept_classes = mask_rdata;
                    out_data_next.last         = (j_inc == count_reg);
                    if (j_inc == count_reg)
                    begin
                        count_next = '0;
                        state_next = pcbn_pkg::ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_inc;
                        state_next = pcbn_pkg::ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = pcbn_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks on the sequencer.
    `PCBN_ASSERT_SAME(a_count_cap, 1'b1, count_reg <= CW'(pcbn_pkg::MAX_DET), "count over capacity")
    `PCBN_ASSERT_SAME(a_col_after_row, state_reg == pcbn_pkg::ST_COL_CALC && mask_we, j_reg > i_reg, "suppression of a higher-priority box")
    `PCBN_ASSERT_SAME(a_iou_only_calc, iou_res.done, state_reg == pcbn_pkg::ST_COL_CALC, "overlap result outside the pair walk")
    `PCBN_ASSERT_NEXT(a_last_to_idle, state_reg == pcbn_pkg::ST_EMIT_WAIT && out_free && j_inc == count_reg, state_reg == pcbn_pkg::ST_IDLE && count_reg == '0, "run did not finish after last result")

endmodule

`default_nettype wire

/* bench/per_class_box_nms_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_class_box_nms_test
// Self-checking bench for the per-class box suppression block. Loads sets of
// boxes, runs suppression under several overlap thresholds and compares every
// kept class mask against a predictor of the greedy per-class scheme.
// ----------------------------------------------------------------------------
`default_nettype none

module per_class_box_nms_test;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    pcbn_pkg::in_item_t            in_data;
    logic                          out_valid;
    logic                          out_stall;
    pcbn_pkg::out_item_t           out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [pcbn_pkg::THR_W-1:0]    cfg_data;

    // Predictor state.
    pcbn_pkg::box_t                   det_boxes [pcbn_pkg::MAX_DET];
    logic [pcbn_pkg::NUM_CLASSES-1:0] det_masks [pcbn_pkg::MAX_DET];
    int                               det_count;
    logic [pcbn_pkg::THR_W-1:0]       thr_now;

    pcbn_pkg::in_item_t  pending_items [$];
    pcbn_pkg::out_item_t kept_expected [$];
    int        fail_count;
    int        gap_left;
    bit        in_hold;

    per_class_box_nms u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [15:0] axis_span(logic [15:0] lo, logic [15:0] hi);
        return (hi > lo) ? hi - lo : 16'd0;
    endfunction

    // True when the IoU of the two boxes reaches the current threshold.
    function automatic bit iou_reaches(pcbn_pkg::box_t a, pcbn_pkg::box_t b);
        logic [32:0] area_a;
        logic [32:0] area_b;
        logic [32:0] inter;
        logic [33:0] uni;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [15:0] ix0, iy0, ix1, iy1;
        area_a = axis_span(a.x_min, a.x_max) * axis_span(a.y_min, a.y_max);
        area_b = axis_span(b.x_min, b.x_max) * axis_span(b.y_min, b.y_max);
        ix0 = (a.x_min > b.x_min) ? a.x_min : b.x_min;
        iy0 = (a.y_min > b.y_min) ? a.y_min : b.y_min;
        ix1 = (a.x_max < b.x_max) ? a.x_max : b.x_max;
        iy1 = (a.y_max < b.y_max) ? a.y_max : b.y_max;
        inter = axis_span(ix0, ix1) * axis_span(iy0, iy1);
        if (inter == 0 || area_a == 0 || area_b == 0)
        begin
            return 1'b0;
        end
        uni = area_a + area_b - inter;
        lhs = {31'd0, inter} << 16;
        rhs = 64'(uni) * 64'(thr_now);
        return lhs >= rhs;
    endfunction

    // Apply one accepted transaction to the predictor.
    task automatic predict_nms(pcbn_pkg::in_item_t item);
        logic [pcbn_pkg::NUM_CLASSES-1:0] common;
        pcbn_pkg::out_item_t              res;
        if (item.cmd == pcbn_pkg::CMD_LOAD)
        begin
            if (det_count < pcbn_pkg::MAX_DET)
            begin
                det_boxes[det_count] = '{item.x_min, item.y_min, item.x_max, item.y_max};
                det_masks[det_count] = item.class_bits;
                det_count++;
            end
        end
        else
        begin
            for (int i = 0; i < det_count; i++)
            begin
                for (int j = i + 1; j < det_count; j++)
                begin
                    common = det_masks[i] & det_masks[j];
                    if (common != 0 && iou_reaches(det_boxes[i], det_boxes[j]))
                    begin
                        det_masks[j] &= ~common;
                    end
                end
            end
            for (int i = 0; i < det_count; i++)
            begin
                res.det_index    = pcbn_pkg::IDX_W'(i);
                res.kept_classes = det_masks[i];
                res.last         = (i == det_count - 1);
                kept_expected.push_back(res);
            end
            det_count = 0;
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
        begin
            return 0;
        end
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    endfunction

    // Driver: offers the next pending transaction after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            predict_nms(in_data);
            void'(pending_items.pop_front());
            if (pending_items.size() > 0 && !in_hold && $urandom_range(0, 2) != 0)
            begin
                in_data <= pending_items[0];
            end
            else
            begin
                in_valid <= 1'b0;
                gap_left <= gap_len();
            end
        end
        else if (!in_valid)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0 && !in_hold)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_items[0];
            end
        end
    end

    // Monitor: checks each result transaction and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (kept_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, out_data);
                    fail_count++;
                end
                else if (out_data !== kept_expected[0])
                begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $time, kept_expected[0], out_data);
                    fail_count++;
                    void'(kept_expected.pop_front());
                end
                else
                begin
                    void'(kept_expected.pop_front());
                end
            end
            out_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
        end
    end

    task automatic load_box(logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
                            logic [15:0] y1, logic [15:0] cls);
        pending_items.push_back('{pcbn_pkg::CMD_LOAD, x0, y0, x1, y1, cls});
    endtask

    task automatic run_nms();
        pcbn_pkg::in_item_t it;
        logic [95:0]        noise;
        noise = {$urandom, $urandom, $urandom};
        it = noise[$bits(pcbn_pkg::in_item_t)-1:0];
        it.cmd = pcbn_pkg::CMD_RUN;
        pending_items.push_back(it);
    endtask

    // Wait until everything queued is accepted and answered.
    task automatic drain();
        while (pending_items.size() > 0 || kept_expected.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_threshold(logic [pcbn_pkg::THR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        thr_now = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A random set, mostly clustered boxes so that overlaps are common, then a run.
    task automatic random_set(int n);
        logic [15:0] cx, cy, w, h, x0, y0;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                load_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
            end
            else
            begin
                cx = ($urandom_range(0, 1) == 0) ? 16'd100 : 16'd65000;
                cy = ($urandom_range(0, 1) == 0) ? 16'd200 : 16'd64000;
                w  = 16'($urandom_range(1, 400));
                h  = 16'($urandom_range(1, 400));
                x0 = cx - 16'($urandom_range(0, 90));
                y0 = cy - 16'($urandom_range(0, 90));
                load_box(x0, y0, x0 + w, y0 + h, 16'(1 << $urandom_range(0, 15)) |
                         (($urandom_range(0, 1) == 0) ? 16'(1 << $urandom_range(0, 15)) : 16'h0));
            end
        end
        run_nms();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_hold    = 1'b0;
        fail_count = 0;
        det_count  = 0;
        thr_now    = pcbn_pkg::THR_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: run with nothing loaded, identical boxes, corner cases.
        run_nms();
        load_box(16'd0, 16'd0, 16'd10, 16'd10, 16'hFFFF);
        load_box(16'd0, 16'd0, 16'd10, 16'd10, 16'h00FF);
        load_box(16'd5, 16'd0, 16'd15, 16'd10, 16'hFF00);
        load_box(16'd20, 16'd20, 16'd10, 16'd10, 16'hFFFF);
        load_box(16'd10, 16'd0, 16'd20, 16'd10, 16'hFFFF);
        load_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8001);
        load_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'h0001);
        load_box(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'h0001);
        load_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'h0000);
        run_nms();
        drain();

        // Overfill: loads beyond capacity are dropped.
        for (int k = 0; k < pcbn_pkg::MAX_DET + 2; k++)
        begin
            load_box(16'(k * 3), 16'd0, 16'(k * 3 + 8), 16'd8, 16'(1 << (k % 16)));
        end
        run_nms();
        drain();

        // Several thresholds, the extremes among them.
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_threshold(17'd0);
                1: write_threshold(17'd65536);
                2: write_threshold(17'h1FFFF);
                3: write_threshold(17'd32768);
                default: write_threshold(17'(pcbn_pkg::THR_RESET));
            endcase
            load_box(16'd0, 16'd0, 16'd10, 16'd10, 16'h0003);
            load_box(16'd0, 16'd0, 16'd10, 16'd10, 16'h0001);
            load_box(16'd3, 16'd3, 16'd13, 16'd13, 16'h0002);
            run_nms();
            random_set($urandom_range(1, 3));
            drain();
        end

        write_threshold(17'($urandom_range(1000, 60000)));
        random_set($urandom_range(2, 6));
        drain();

        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
